// File: rtl/mbrm_pkg.sv
// Constants, status and function codes, and helpers for the Modbus slave register map.
package mbrm_pkg;

   localparam int HOLDING_DEPTH = 16;
   localparam int INPUT_DEPTH   = 8;
   localparam int MAX_RESULTS   = 16;
   localparam int SENSOR_REGS   = 4;

   localparam int HOLD_AW = $clog2(HOLDING_DEPTH);
   localparam int IN_AW   = $clog2(INPUT_DEPTH);
   localparam int RD_AW   = (HOLD_AW > IN_AW) ? HOLD_AW : IN_AW;
   localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int SEN_W   = $clog2(SENSOR_REGS);

   localparam int FC_W     = 8;
   localparam int WORD_W   = 16;
   localparam int ADC_W    = 12;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;

   localparam logic [STATUS_W-1:0] STATUS_DATA    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADADDR = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNSUP   = 2'd3;

   localparam logic [FC_W-1:0] FC_READ_HOLD  = 8'h03;
   localparam logic [FC_W-1:0] FC_READ_INPUT = 8'h04;
   localparam logic [FC_W-1:0] FC_WRITE_ONE  = 8'h06;

   localparam logic [WORD_W-1:0] OTA_REG     = 16'd3;
   localparam logic [WORD_W-1:0] HOLD0_RESET = 16'd1000;
   localparam logic [WORD_W-1:0] HOLD1_RESET = 16'd100;

   function automatic logic [WORD_W-1:0] hold_reset(input logic [HOLD_AW-1:0] idx);
      logic [WORD_W-1:0] val;
      val = '0;
      if (idx == HOLD_AW'(0)) begin
         val = HOLD0_RESET;
      end else if (idx == HOLD_AW'(1)) begin
         val = HOLD1_RESET;
      end
      return val;
   endfunction

endpackage

// File: rtl/modbus_slave_register_map_core.sv
// Modbus slave register map: holding and input register stores with request sequencing.
// A write, a zero-length read, an error or an unsupported code gives its result from the
// ST_SINGLE state when the output is free, and the block takes no new request until idle.
// A read of N registers gives one result per cycle while the output does not stall, paced
// by the single read port of the register memories, through the pending and result registers.
// A sensor update writes its four input registers one per cycle, then gives its result from ST_SINGLE.
// Reset is synchronous; per-entry valid bits make unwritten registers read as reset values.
module modbus_slave_register_map_core import mbrm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [FC_W-1:0]     req_function_code,
   input  logic [WORD_W-1:0]   req_address,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic [WORD_W-1:0]   req_temperature_tenths,
   input  logic [WORD_W-1:0]   req_humidity_tenths,
   input  logic [ADC_W-1:0]    req_adc_value,
   input  logic [WORD_W-1:0]   req_timestamp_low,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_register_index,
   output logic [WORD_W-1:0]   rsp_read_value,
   output logic                rsp_last_item,
   output logic                rsp_ota_request
);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SENSOR, ST_SINGLE} state_type;

   logic [WORD_W-1:0] hold_mem [HOLDING_DEPTH];
   logic [WORD_W-1:0] in_mem [INPUT_DEPTH];

   state_type state_ff, state_in;
   logic [HOLDING_DEPTH-1:0] hold_vld_ff, hold_vld_in;
   logic [INPUT_DEPTH-1:0] in_vld_ff, in_vld_in;
   logic [RD_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0] rd_left_ff, rd_left_in;
   logic sel_input_ff, sel_input_in;
   logic pend_ff, pend_in;
   logic pend_last_ff, pend_last_in;
   logic [INDEX_W-1:0] pend_idx_ff, pend_idx_in;
   logic pend_vld_ff, pend_vld_in;
   logic [WORD_W-1:0] pend_rst_ff, pend_rst_in;
   logic [WORD_W-1:0] hold_rd_ff, in_rd_ff;
   logic [WORD_W-1:0] sens_ff [SENSOR_REGS];
   logic [WORD_W-1:0] sens_in [SENSOR_REGS];
   logic [SEN_W-1:0] sen_cnt_ff, sen_cnt_in;
   logic [STATUS_W-1:0] sgl_status_ff, sgl_status_in;
   logic [INDEX_W-1:0] sgl_idx_ff, sgl_idx_in;
   logic [WORD_W-1:0] sgl_val_ff, sgl_val_in;
   logic sgl_ota_ff, sgl_ota_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [WORD_W-1:0] rsp_val_ff, rsp_val_in;
   logic rsp_last_ff, rsp_last_in;
   logic rsp_ota_ff, rsp_ota_in;

   logic out_free;
   logic req_acc;
   logic rd_issue;
   logic hold_we;
   logic [HOLD_AW-1:0] hold_waddr;
   logic in_we;
   logic [IN_AW-1:0] in_waddr;
   logic [WORD_W-1:0] in_wdata;
   logic [WORD_W:0] rd_span;
   logic count_big;
   logic hold_bad;
   logic in_bad;
   logic rd_bad;
   logic wr_ok;
   logic [WORD_W-1:0] pend_value;

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_register_index = rsp_idx_ff;
   assign rsp_read_value     = rsp_val_ff;
   assign rsp_last_item      = rsp_last_ff;
   assign rsp_ota_request    = rsp_ota_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_acc  = req_valid && !req_stall;
   assign rd_issue = (state_ff == ST_READ) && (rd_left_ff != '0) && (!pend_ff || out_free);

   assign rd_span   = {1'b0, req_address} + {1'b0, req_data_word};
   assign count_big = req_data_word > WORD_W'(MAX_RESULTS);
   assign hold_bad  = count_big || (rd_span > (WORD_W + 1)'(HOLDING_DEPTH));
   assign in_bad    = count_big || (rd_span > (WORD_W + 1)'(INPUT_DEPTH));
   assign rd_bad    = (req_function_code == FC_READ_INPUT) ? in_bad : hold_bad;
   assign wr_ok     = req_address < WORD_W'(HOLDING_DEPTH);
   assign hold_waddr = req_address[HOLD_AW-1:0];
   assign pend_value = pend_vld_ff ? (sel_input_ff ? in_rd_ff : hold_rd_ff) : pend_rst_ff;

   always_comb begin
      state_in      = state_ff;
      hold_vld_in   = hold_vld_ff;
      in_vld_in     = in_vld_ff;
      rd_addr_in    = rd_addr_ff;
      rd_left_in    = rd_left_ff;
      sel_input_in  = sel_input_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      pend_idx_in   = pend_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_rst_in   = pend_rst_ff;
      sens_in       = sens_ff;
      sen_cnt_in    = sen_cnt_ff;
      sgl_status_in = sgl_status_ff;
      sgl_idx_in    = sgl_idx_ff;
      sgl_val_in    = sgl_val_ff;
      sgl_ota_in    = sgl_ota_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ota_in    = rsp_ota_ff;
      hold_we       = 1'b0;
      in_we         = 1'b0;
      in_waddr      = IN_AW'(sen_cnt_ff);
      in_wdata      = sens_ff[sen_cnt_ff];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sgl_idx_in = '0;
               sgl_val_in = '0;
               sgl_ota_in = 1'b0;
               if (req_type) begin
                  sens_in[0] = req_temperature_tenths;
                  sens_in[1] = req_humidity_tenths;
                  sens_in[2] = WORD_W'(req_adc_value);
                  sens_in[3] = req_timestamp_low;
                  sen_cnt_in = '0;
                  state_in   = ST_SENSOR;
               end else begin
                  unique case (req_function_code) inside
                     FC_READ_HOLD, FC_READ_INPUT: begin
                        sel_input_in = (req_function_code == FC_READ_INPUT);
                        if (rd_bad) begin
                           sgl_status_in = STATUS_BADADDR;
                           state_in      = ST_SINGLE;
                        end else if (req_data_word == '0) begin
                           sgl_status_in = STATUS_DONE;
                           state_in      = ST_SINGLE;
                        end else begin
                           rd_addr_in = RD_AW'(req_address);
                           rd_left_in = CNT_W'(req_data_word);
                           pend_in    = 1'b0;
                           state_in   = ST_READ;
                        end
                     end
                     FC_WRITE_ONE: begin
                        state_in = ST_SINGLE;
                        if (wr_ok) begin
                           hold_we                 = 1'b1;
                           hold_vld_in[hold_waddr] = 1'b1;
                           sgl_status_in           = STATUS_DONE;
                           sgl_idx_in              = INDEX_W'(req_address);
                           sgl_val_in              = req_data_word;
                           sgl_ota_in              = (req_address == OTA_REG) &&
                                                     (req_data_word == WORD_W'(1));
                        end else begin
                           sgl_status_in = STATUS_BADADDR;
                        end
                     end
                     default: begin
                        sgl_status_in = STATUS_UNSUP;
                        state_in      = ST_SINGLE;
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            if (pend_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DATA;
               rsp_idx_in    = pend_idx_ff;
               rsp_val_in    = pend_value;
               rsp_last_in   = pend_last_ff;
               rsp_ota_in    = 1'b0;
               pend_in       = 1'b0;
               if (pend_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
            if (rd_issue) begin
               rd_addr_in   = rd_addr_ff + RD_AW'(1);
               rd_left_in   = rd_left_ff - CNT_W'(1);
               pend_in      = 1'b1;
               pend_last_in = (rd_left_ff == CNT_W'(1));
               pend_idx_in  = INDEX_W'(rd_addr_ff);
               if (sel_input_ff) begin
                  pend_vld_in = in_vld_ff[rd_addr_ff[IN_AW-1:0]];
                  pend_rst_in = '0;
               end else begin
                  pend_vld_in = hold_vld_ff[rd_addr_ff[HOLD_AW-1:0]];
                  pend_rst_in = hold_reset(rd_addr_ff[HOLD_AW-1:0]);
               end
            end
         end
         ST_SENSOR: begin
            in_we               = 1'b1;
            in_vld_in[in_waddr] = 1'b1;
            sen_cnt_in          = sen_cnt_ff + SEN_W'(1);
            if (sen_cnt_ff == SEN_W'(SENSOR_REGS - 1)) begin
               sgl_status_in = STATUS_DONE;
               state_in      = ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sgl_status_ff;
               rsp_idx_in    = sgl_idx_ff;
               rsp_val_in    = sgl_val_ff;
               rsp_last_in   = 1'b1;
               rsp_ota_in    = sgl_ota_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_mem[hold_waddr] <= req_data_word;
      end
      if (in_we) begin
         in_mem[in_waddr] <= in_wdata;
      end
      if (rd_issue) begin
         hold_rd_ff <= hold_mem[rd_addr_ff[HOLD_AW-1:0]];
         in_rd_ff   <= in_mem[rd_addr_ff[IN_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hold_vld_ff  <= '0;
         in_vld_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_vld_ff  <= hold_vld_in;
         in_vld_ff    <= in_vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff    <= rd_addr_in;
      rd_left_ff    <= rd_left_in;
      sel_input_ff  <= sel_input_in;
      pend_last_ff  <= pend_last_in;
      pend_idx_ff   <= pend_idx_in;
      pend_vld_ff   <= pend_vld_in;
      pend_rst_ff   <= pend_rst_in;
      sens_ff       <= sens_in;
      sen_cnt_ff    <= sen_cnt_in;
      sgl_status_ff <= sgl_status_in;
      sgl_idx_ff    <= sgl_idx_in;
      sgl_val_ff    <= sgl_val_in;
      sgl_ota_ff    <= sgl_ota_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ota_ff    <= rsp_ota_in;
   end

endmodule

// File: tb/modbus_slave_register_map_core_test.sv
// Testbench for the Modbus slave register map core with a built-in register map predictor.
`timescale 1ns / 1ps

module modbus_slave_register_map_core_test;
   import mbrm_pkg::*;

   localparam int   CYCLE_LIMIT  = 200000;
   localparam int   DRAIN_CYCLES = 40;
   localparam int   RANDOM_ITEMS = 126;
   localparam logic KIND_MODBUS  = 1'b0;
   localparam logic KIND_SENSOR  = 1'b1;

   typedef struct {
      logic                kind;
      logic [FC_W-1:0]     fc;
      logic [WORD_W-1:0]   addr;
      logic [WORD_W-1:0]   data;
      logic [WORD_W-1:0]   temp;
      logic [WORD_W-1:0]   hum;
      logic [ADC_W-1:0]    adc;
      logic [WORD_W-1:0]   stamp;
   } request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [WORD_W-1:0]   value;
      logic                last;
      logic                ota;
   } reply_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_type;
   logic [FC_W-1:0]     req_function_code;
   logic [WORD_W-1:0]   req_address;
   logic [WORD_W-1:0]   req_data_word;
   logic [WORD_W-1:0]   req_temperature_tenths;
   logic [WORD_W-1:0]   req_humidity_tenths;
   logic [ADC_W-1:0]    req_adc_value;
   logic [WORD_W-1:0]   req_timestamp_low;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_register_index;
   logic [WORD_W-1:0]   rsp_read_value;
   logic                rsp_last_item;
   logic                rsp_ota_request;

   request_type       pending_requests[$];
   reply_type         expected_replies[$];
   logic [WORD_W-1:0] holding_copy[HOLDING_DEPTH];
   logic [WORD_W-1:0] input_copy[INPUT_DEPTH];
   request_type       next_req;
   request_type       seen_req;
   reply_type         want;
   int                requests_sent = 0;
   int                cycles = 0;
   bit                failed = 0;
   logic              req_taken = 0;
   logic              calm;

   modbus_slave_register_map_core u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_type               (req_type),
      .req_function_code      (req_function_code),
      .req_address            (req_address),
      .req_data_word          (req_data_word),
      .req_temperature_tenths (req_temperature_tenths),
      .req_humidity_tenths    (req_humidity_tenths),
      .req_adc_value          (req_adc_value),
      .req_timestamp_low      (req_timestamp_low),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_register_index     (rsp_register_index),
      .rsp_read_value         (rsp_read_value),
      .rsp_last_item          (rsp_last_item),
      .rsp_ota_request        (rsp_ota_request)
   );

   always #5 clock = ~clock;

   // Neither side idles while this stretch of requests is transferred.
   assign calm = (requests_sent >= 70) && (requests_sent < 110);

   function automatic void push_reply(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] index,
                                      logic [WORD_W-1:0] value, logic last, logic ota);
      reply_type r;
      r.status = status;
      r.index  = index;
      r.value  = value;
      r.last   = last;
      r.ota    = ota;
      expected_replies.push_back(r);
   endfunction

   function automatic void predict_read(bit from_input, int unsigned start, int unsigned count);
      int unsigned depth;
      int unsigned i;
      logic [WORD_W-1:0] value;
      depth = from_input ? INPUT_DEPTH : HOLDING_DEPTH;
      if (count > MAX_RESULTS || start + count > depth) begin
         push_reply(STATUS_BADADDR, '0, '0, 1'b1, 1'b0);
      end else if (count == 0) begin
         push_reply(STATUS_DONE, '0, '0, 1'b1, 1'b0);
      end else begin
         for (i = 0; i < count; i++) begin
            value = from_input ? input_copy[start + i] : holding_copy[start + i];
            push_reply(STATUS_DATA, INDEX_W'(start + i), value, (i + 1 == count), 1'b0);
         end
      end
   endfunction

   function automatic void predict_register_map(request_type r);
      if (r.kind == KIND_SENSOR) begin
         input_copy[0] = r.temp;
         input_copy[1] = r.hum;
         input_copy[2] = WORD_W'(r.adc);
         input_copy[3] = r.stamp;
         push_reply(STATUS_DONE, '0, '0, 1'b1, 1'b0);
      end else begin
         case (r.fc)
            FC_READ_HOLD: begin
               predict_read(1'b0, r.addr, r.data);
            end
            FC_READ_INPUT: begin
               predict_read(1'b1, r.addr, r.data);
            end
            FC_WRITE_ONE: begin
               if (r.addr >= HOLDING_DEPTH) begin
                  push_reply(STATUS_BADADDR, '0, '0, 1'b1, 1'b0);
               end else begin
                  holding_copy[r.addr] = r.data;
                  push_reply(STATUS_DONE, INDEX_W'(r.addr), r.data, 1'b1,
                             (r.addr == OTA_REG) && (r.data == WORD_W'(1)));
               end
            end
            default: begin
               push_reply(STATUS_UNSUP, '0, '0, 1'b1, 1'b0);
            end
         endcase
      end
   endfunction

   function automatic void add_modbus(logic [FC_W-1:0] fc, logic [WORD_W-1:0] addr,
                                      logic [WORD_W-1:0] data);
      request_type r;
      r.kind  = KIND_MODBUS;
      r.fc    = fc;
      r.addr  = addr;
      r.data  = data;
      r.temp  = WORD_W'($urandom);
      r.hum   = WORD_W'($urandom);
      r.adc   = ADC_W'($urandom);
      r.stamp = WORD_W'($urandom);
      pending_requests.push_back(r);
   endfunction

   function automatic void add_sensor(logic [WORD_W-1:0] temp, logic [WORD_W-1:0] hum,
                                      logic [ADC_W-1:0] adc, logic [WORD_W-1:0] stamp);
      request_type r;
      r.kind  = KIND_SENSOR;
      r.fc    = FC_W'($urandom);
      r.addr  = WORD_W'($urandom);
      r.data  = WORD_W'($urandom);
      r.temp  = temp;
      r.hum   = hum;
      r.adc   = adc;
      r.stamp = stamp;
      pending_requests.push_back(r);
   endfunction

   function automatic logic [FC_W-1:0] pick_known_code();
      logic [FC_W-1:0] fc;
      case ($urandom_range(0, 2))
         0: fc = FC_READ_HOLD;
         1: fc = FC_READ_INPUT;
         default: fc = FC_WRITE_ONE;
      endcase
      return fc;
   endfunction

   task automatic check_field(string name, logic [WORD_W-1:0] expected_value,
                              logic [WORD_W-1:0] actual_value);
      if (expected_value !== actual_value) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                  expected_value, actual_value);
         failed = 1;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
               next_req = pending_requests.pop_front();
               req_valid              <= 1'b1;
               req_type               <= next_req.kind;
               req_function_code      <= next_req.fc;
               req_address            <= next_req.addr;
               req_data_word          <= next_req.data;
               req_temperature_tenths <= next_req.temp;
               req_humidity_tenths    <= next_req.hum;
               req_adc_value          <= next_req.adc;
               req_timestamp_low      <= next_req.stamp;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 33);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected result, status %0d index %0d value %0h", $time,
                        rsp_status, rsp_register_index, rsp_read_value);
               failed = 1;
            end else begin
               want = expected_replies.pop_front();
               check_field("status", WORD_W'(want.status), WORD_W'(rsp_status));
               check_field("register_index", WORD_W'(want.index), WORD_W'(rsp_register_index));
               check_field("read_value", want.value, rsp_read_value);
               check_field("last_item", WORD_W'(want.last), WORD_W'(rsp_last_item));
               check_field("ota_request", WORD_W'(want.ota), WORD_W'(rsp_ota_request));
            end
         end
         // Results of earlier transfers are checked above before this transfer is predicted.
         if (req_valid && !req_stall) begin
            seen_req.kind  = req_type;
            seen_req.fc    = req_function_code;
            seen_req.addr  = req_address;
            seen_req.data  = req_data_word;
            seen_req.temp  = req_temperature_tenths;
            seen_req.hum   = req_humidity_tenths;
            seen_req.adc   = req_adc_value;
            seen_req.stamp = req_timestamp_low;
            predict_register_map(seen_req);
            requests_sent = requests_sent + 1;
         end
      end
   end

   initial begin
      int sel;
      int unsigned cnt;
      int unsigned a;
      logic [WORD_W-1:0] d;
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_valid              = 1'b0;
      rsp_stall              = 1'b0;
      req_type               = KIND_MODBUS;
      req_function_code      = '0;
      req_address            = '0;
      req_data_word          = '0;
      req_temperature_tenths = '0;
      req_humidity_tenths    = '0;
      req_adc_value          = '0;
      req_timestamp_low      = '0;
      for (int i = 0; i < HOLDING_DEPTH; i++) begin
         holding_copy[i] = '0;
      end
      for (int i = 0; i < INPUT_DEPTH; i++) begin
         input_copy[i] = '0;
      end
      holding_copy[0] = HOLD0_RESET;
      holding_copy[1] = HOLD1_RESET;

      add_modbus(FC_READ_HOLD, 16'd0, 16'd16);
      add_modbus(FC_READ_INPUT, 16'd0, 16'd8);
      add_sensor(16'hFFFF, 16'h0000, 12'hFFF, 16'hA5A5);
      add_sensor(16'h0000, 16'hFFFF, 12'h000, 16'h5A5A);
      add_modbus(FC_READ_INPUT, 16'd0, 16'd8);
      add_modbus(FC_WRITE_ONE, OTA_REG, 16'd1);
      add_modbus(FC_WRITE_ONE, OTA_REG, 16'd0);
      add_modbus(FC_WRITE_ONE, 16'd15, 16'hFFFF);
      add_modbus(FC_WRITE_ONE, 16'd16, 16'h1234);
      add_modbus(FC_WRITE_ONE, 16'hFFFF, 16'd1);
      add_modbus(FC_READ_HOLD, 16'd4, 16'd0);
      add_modbus(FC_READ_HOLD, 16'd15, 16'd1);
      add_modbus(FC_READ_HOLD, 16'd15, 16'd2);
      add_modbus(FC_READ_HOLD, 16'd0, 16'd17);
      add_modbus(FC_READ_HOLD, 16'hFFF0, 16'd16);
      add_modbus(FC_READ_INPUT, 16'hFFFF, 16'hFFFF);
      add_modbus(FC_READ_INPUT, 16'd7, 16'd1);
      add_modbus(FC_READ_INPUT, 16'd8, 16'd0);
      add_modbus(FC_READ_INPUT, 16'd9, 16'd0);
      add_modbus(8'h00, 16'd0, 16'd1);
      add_modbus(8'hFF, 16'hFFFF, 16'hFFFF);
      add_modbus(8'h05, 16'd1, 16'd1);
      add_modbus(FC_WRITE_ONE, 16'd0, 16'd0);
      add_modbus(FC_READ_HOLD, 16'd0, 16'd16);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 10) begin
            add_sensor(WORD_W'($urandom), WORD_W'($urandom), ADC_W'($urandom),
                       WORD_W'($urandom));
         end else if (sel < 40) begin
            cnt = $urandom_range(1, HOLDING_DEPTH);
            a   = $urandom_range(0, HOLDING_DEPTH - cnt);
            add_modbus(FC_READ_HOLD, WORD_W'(a), WORD_W'(cnt));
         end else if (sel < 58) begin
            cnt = $urandom_range(1, INPUT_DEPTH);
            a   = $urandom_range(0, INPUT_DEPTH - cnt);
            add_modbus(FC_READ_INPUT, WORD_W'(a), WORD_W'(cnt));
         end else if (sel < 64) begin
            add_modbus(FC_WRITE_ONE, OTA_REG, WORD_W'($urandom_range(0, 1)));
         end else if (sel < 82) begin
            a = $urandom_range(0, HOLDING_DEPTH - 1);
            d = ($urandom_range(0, 3) == 0) ? WORD_W'(1) : WORD_W'($urandom);
            add_modbus(FC_WRITE_ONE, WORD_W'(a), d);
         end else begin
            a = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20);
            d = $urandom_range(0, 1) ? WORD_W'($urandom) : WORD_W'($urandom_range(0, 20));
            add_modbus($urandom_range(0, 2) == 0 ? FC_W'($urandom) : pick_known_code(),
                       WORD_W'(a), d);
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failed) begin
         $display("FAILURE");
      end else begin
         $display("SUCCESS");
      end
      $finish;
   end

endmodule
